// File: hw/rtl/pfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;
    localparam int Ratio = 64;
    localparam int Taps = 128;
    localparam int HistDepth = 256;
    localparam int CoefDepth = 8192;
    localparam int HistAw = $clog2(HistDepth);
    localparam int CoefAw = $clog2(CoefDepth);
    localparam int TapAw = $clog2(Taps);
    localparam int RowAw = $clog2(Ratio);
    localparam int AccW = 23;
    localparam int SampW = 24;
    localparam int OneQ16 = 65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_DOT,
        ST_DRAIN,
        ST_DOT_DONE,
        ST_BLEND_MUL,
        ST_BLEND_ADD,
        ST_EMIT,
        ST_STEP
    } pfr_state_t;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF = 1'b1;
endpackage
`default_nettype wire

// File: hw/rtl/pfr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_ram #(
    parameter int Width = 24,
    parameter int Depth = 256
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(Depth)-1:0]  waddr,
    input  wire [Width-1:0]          wdata,
    input  wire [$clog2(Depth)-1:0]  raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/polyphase_fractional_resampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Polyphase fractional resampler. Each sample request (command 0) is written
// into a 256-entry history ring and then produces one to 64 output requests,
// each a 128-tap dot product, or the linear blend of two taken from adjacent
// coefficient rows; the last output of a run carries last_of_run. A command 1
// request writes one coefficient word and produces nothing. History and the
// coefficient table sit in synchronous RAMs with a registered read, and one
// multiply-accumulate unit walks both, one tap per cycle. An output with a
// nonzero phase fraction runs two passes of 128 taps, each followed by a
// drain state and a finish state, then blend multiply, blend add, handoff to
// the output register and the accumulator step. With a zero fraction only
// one pass is run. The handoff waits for every cycle in which the output
// register is full and not taken. A sample request passes a write state and
// a check state before its outputs, and the next request is taken only once
// its last output is handed off, while coefficient requests are taken one
// per cycle whenever the block is idle. After reset the block first sweeps
// the history RAM to zero and accepts no request until the sweep is done.
// A phase_step write takes effect at once, so it belongs between sample
// requests, never while one is being processed.
module polyphase_fractional_resampler_unit (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire [pfr_pkg::AccW-1:0]      cfg_wdata,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_command,
    input  wire signed [23:0]            s_sample_in,
    input  wire [12:0]                   s_coef_index,
    input  wire signed [23:0]            s_coef_value,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [23:0]           m_sample_out,
    output logic                         m_last_of_run
);
    import pfr_pkg::*;

    localparam logic [AccW-1:0] StepMin = AccW'(OneQ16);
    localparam logic [AccW-1:0] StepMax = AccW'(Ratio * OneQ16);
    localparam logic [AccW:0] AccReset = (AccW+1)'((Ratio - 1) * OneQ16);

    pfr_state_t state_reg, state_next;
    logic [AccW-1:0] step_reg;
    logic clr_busy_reg;
    logic [HistAw-1:0] clr_addr_reg;
    logic [HistAw-1:0] wp_reg, wp_next;
    // One extra sign bit so the loop sees the accumulator going negative.
    logic signed [AccW:0] acc_reg, acc_next;
    logic second_reg, second_next;
    logic [TapAw:0] tap_reg, tap_next;
    logic mac_en_reg;
    logic signed [63:0] sum_reg;
    logic signed [63:0] d1_reg, d1_next;
    logic signed [63:0] prod_reg;
    logic signed [24:0] res_reg, res_next;
    logic m_valid_reg;
    logic signed [SampW-1:0] m_data_reg;
    logic m_last_reg;
    logic signed [SampW-1:0] samp_reg;

    // Memory ports.
    logic h_we;
    logic [HistAw-1:0] h_waddr, h_raddr;
    logic [SampW-1:0] h_wdata, h_rdata;
    logic c_we;
    logic [CoefAw-1:0] c_waddr, c_raddr;
    logic [SampW-1:0] c_rdata;

    pfr_ram #(.Width(SampW), .Depth(HistDepth)) u_hist (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );
    pfr_ram #(.Width(SampW), .Depth(CoefDepth)) u_coef (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(s_coef_value),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    // Clamped step; the register may hold anything.
    logic [AccW-1:0] step_use;
    always_comb begin
        step_use = step_reg;
        if (step_reg < StepMin) begin
            step_use = StepMin;
        end
        if (step_reg > StepMax) begin
            step_use = StepMax;
        end
    end

    // Accumulator after one step; the step is widened as a positive value so
    // the difference stays signed.
    logic signed [AccW:0] acc_sub;
    assign acc_sub = acc_reg - $signed({1'b0, step_use});

    // Phase index for the dot product in flight: floor(p), plus one on the
    // second pass. Phase Ratio wraps to row 0, one sample further on.
    logic [RowAw:0] ph;
    logic [RowAw-1:0] row;
    logic [HistAw-1:0] base;
    logic [15:0] frac;
    assign frac = acc_reg[15:0];
    assign ph = (RowAw+1)'(acc_reg[AccW-1:16]) + (RowAw+1)'(second_reg);
    assign row = ph[RowAw-1:0];
    assign base = wp_reg + HistAw'(ph[RowAw]) + HistAw'(1);

    logic [TapAw-1:0] tap_idx;
    assign tap_idx = tap_reg[TapAw-1:0];
    assign h_raddr = base + HistAw'(tap_idx);
    assign c_raddr = CoefAw'({row, tap_idx});

    logic s_fire;
    assign s_ready = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign s_fire = s_valid && s_ready;
    assign c_we = s_fire && (s_command == CMD_COEF);
    assign c_waddr = s_coef_index;

    always_comb begin
        h_we = 1'b0;
        h_waddr = wp_reg;
        h_wdata = samp_reg;
        if (clr_busy_reg) begin
            h_we = 1'b1;
            h_waddr = clr_addr_reg;
            h_wdata = '0;
        end else if (state_reg == ST_WRITE) begin
            h_we = 1'b1;
        end
    end

    // Blend arithmetic.
    logic signed [63:0] dot_rnd;
    assign dot_rnd = (sum_reg + 64'sd2048) >>> 12;
    // A rounded dot product stays below 2^42 in magnitude, so the difference
    // of two fits in 44 bits.
    logic signed [43:0] dot_diff;
    assign dot_diff = 44'(dot_rnd - d1_reg);
    logic signed [60:0] blend_prod;
    assign blend_prod = dot_diff * $signed({1'b0, frac});
    logic signed [63:0] blend_v;
    assign blend_v = d1_reg + ((prod_reg + 64'sd32768) >>> 16);
    logic signed [63:0] out_rnd;
    logic signed [24:0] sat_v;
    always_comb begin
        out_rnd = (blend_v + 64'sd128) >>> 8;
        if (out_rnd > 64'sd8388607) begin
            sat_v = 25'sd8388607;
        end else if (out_rnd < -64'sd8388608) begin
            sat_v = -25'sd8388608;
        end else begin
            sat_v = 25'(out_rnd);
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        wp_next = wp_reg;
        acc_next = acc_reg;
        second_next = second_reg;
        tap_next = tap_reg;
        d1_next = d1_reg;
        res_next = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_command == CMD_SAMPLE) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                wp_next = wp_reg - HistAw'(1);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                second_next = 1'b0;
                tap_next = '0;
                if (acc_reg < 0) begin
                    acc_next = acc_reg + (AccW+1)'(Ratio * OneQ16);
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                tap_next = tap_reg + 1'b1;
                if (tap_reg == (TapAw+1)'(Taps - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DOT_DONE;
            ST_DOT_DONE: begin
                tap_next = '0;
                if (!second_reg) begin
                    d1_next = dot_rnd;
                    if (frac != 16'd0) begin
                        second_next = 1'b1;
                        state_next = ST_DOT;
                    end else begin
                        state_next = ST_BLEND_ADD;
                    end
                end else begin
                    state_next = ST_BLEND_MUL;
                end
            end
            ST_BLEND_MUL: state_next = ST_BLEND_ADD;
            ST_BLEND_ADD: begin
                res_next = sat_v;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                second_next = 1'b0;
                tap_next = '0;
                if (acc_sub < 0) begin
                    acc_next = acc_sub + (AccW+1)'(Ratio * OneQ16);
                    state_next = ST_IDLE;
                end else begin
                    acc_next = acc_sub;
                    state_next = ST_DOT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Last output of the run: the step would take the accumulator negative.
    logic emit_last;
    assign emit_last = acc_sub < 0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= StepMax;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            wp_reg <= '0;
            acc_reg <= AccReset;
            second_reg <= 1'b0;
            tap_reg <= '0;
            mac_en_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wp_reg <= wp_next;
            acc_reg <= acc_next;
            second_reg <= second_next;
            tap_reg <= tap_next;
            mac_en_reg <= (state_reg == ST_DOT);
            if (cfg_we) begin
                step_reg <= cfg_wdata;
            end
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == HistAw'(HistDepth - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the multiply-accumulate unit. After the second
    // pass the sum is kept through the finish state for the blend multiply.
    always_ff @(posedge aclk) begin
        d1_reg <= d1_next;
        res_reg <= res_next;
        if (s_fire) begin
            samp_reg <= s_sample_in;
        end
        if (state_reg == ST_CHECK || state_reg == ST_STEP
            || (state_reg == ST_DOT_DONE && !second_reg)) begin
            sum_reg <= '0;
        end else if (mac_en_reg) begin
            sum_reg <= sum_reg + 64'($signed(h_rdata) * $signed(c_rdata));
        end
        if (state_reg == ST_DOT_DONE) begin
            prod_reg <= '0;
        end else if (state_reg == ST_BLEND_MUL) begin
            prod_reg <= 64'(blend_prod);
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg <= res_reg[SampW-1:0];
            m_last_reg <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_sample_out = m_data_reg;
    assign m_last_of_run = m_last_reg;
endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    // Testbench for the polyphase fractional resampler. A driver process
    // feeds sample and coefficient requests from a queue of pending requests,
    // and a monitor process checks every output request against a predictor
    // of the resampler that is kept inside this module. Only coefficient row
    // Ratio-1 is loaded, and every step in use is 64.0 or clamps to it, so
    // each sample reads that row alone and never an unwritten entry.
    import pfr_pkg::*;

    // Far above a run in which every sample caused 64 two-pass outputs.
    localparam int CycleLimit = 20_000_000;
    // Cycles to let pass before a phase_step write once nothing is expected.
    localparam int SettleCycles = 600;
    // First table address of the one coefficient row in use.
    localparam logic [12:0] RowBase = 13'((Ratio - 1) * Taps);

    typedef struct {
        logic                command;
        logic signed [23:0]  sample;
        logic [12:0]         index;
        logic signed [23:0]  value;
    } req_t;

    typedef struct {
        logic signed [23:0]  sample;
        logic                last;
    } out_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [AccW-1:0]         cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_command = CMD_SAMPLE;
    logic signed [23:0]      s_sample_in = '0;
    logic [12:0]             s_coef_index = '0;
    logic signed [23:0]      s_coef_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [23:0]      m_sample_out;
    logic                    m_last_of_run;

    polyphase_fractional_resampler_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_sample_in   (s_sample_in),
        .s_coef_index  (s_coef_index),
        .s_coef_value  (s_coef_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus and expectations shared by the processes below.
    req_t  pending_reqs[$];
    out_t  expected_outs[$];
    int    send_idle = 30;
    int    recv_idle = 84;
    int    errors = 0;
    int    cycles = 0;
    int    samples_sent = 0;
    int    coefs_sent = 0;
    int    outs_checked = 0;

    // Shadow of the resampler state, updated on every accepted request.
    logic signed [23:0]  hist_ram [HistDepth];
    logic signed [23:0]  coef_ram [CoefDepth];
    int                  wr_ptr;
    int                  phase_acc;
    logic [AccW-1:0]     step_q16;

    task automatic report(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // Dot product of the history with one coefficient row. Oversampled phase
    // Ratio lands on row 0, one history sample further on. Result is Q.31.
    function automatic longint phase_dot(input int ph);
        int     idx;
        int     row;
        longint sum;
        idx = (wr_ptr + ph / Ratio) % HistDepth;
        row = ph % Ratio;
        sum = 0;
        for (int k = 0; k < Taps; k++) begin
            idx = (idx + 1) % HistDepth;
            sum += longint'(hist_ram[idx]) * longint'(coef_ram[(k + row * Taps) % CoefDepth]);
        end
        return (sum + (64'sd1 <<< 11)) >>> 12;
    endfunction

    // One output at accumulator value p: blend of two adjacent phases, or the
    // first phase alone when the fraction is zero, then round and saturate.
    function automatic logic signed [23:0] blend_at(input int p);
        longint d1;
        longint d2;
        longint v;
        int     frac;
        frac = p & 'hFFFF;
        d1 = phase_dot(p >> 16);
        v = d1;
        if (frac != 0) begin
            d2 = phase_dot((p >> 16) + 1);
            v = d1 + (((d2 - d1) * frac + (64'sd1 <<< 15)) >>> 16);
        end
        v = (v + 128) >>> 8;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    // Apply one accepted request to the shadow state and queue its outputs.
    task automatic predict_request(input req_t r);
        int   step;
        int   acc;
        out_t o;
        if (r.command == CMD_COEF) begin
            coef_ram[r.index] = r.value;
            return;
        end
        hist_ram[wr_ptr] = r.sample;
        wr_ptr = (wr_ptr + HistDepth - 1) % HistDepth;
        step = int'(step_q16);
        if (step < OneQ16) step = OneQ16;
        if (step > Ratio * OneQ16) step = Ratio * OneQ16;
        acc = phase_acc;
        while (acc >= 0) begin
            o.sample = blend_at(acc);
            acc -= step;
            // The run ends once the accumulator goes negative.
            o.last = (acc < 0);
            expected_outs = {expected_outs, o};
        end
        phase_acc = acc + Ratio * OneQ16;
    endtask

    // Driver: takes the next pending request when the channel is free,
    // sometimes holding off to leave a gap.
    always @(posedge aclk) begin
        req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                r.command = s_command;
                r.sample = s_sample_in;
                r.index = s_coef_index;
                r.value = s_coef_value;
                predict_request(r);
                if (s_command == CMD_COEF) coefs_sent++;
                else samples_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                    r = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_command <= r.command;
                    s_sample_in <= r.sample;
                    s_coef_index <= r.index;
                    s_coef_value <= r.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Monitor: every accepted output is checked against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outs.size() == 0) begin
                report($sformatf("output %0d with nothing expected", m_sample_out));
            end else begin
                e = expected_outs.pop_front();
                outs_checked++;
                if (m_sample_out !== e.sample)
                    report($sformatf("sample_out %0d, expected %0d", m_sample_out, e.sample));
                if (m_last_of_run !== e.last)
                    report($sformatf("last_of_run %b, expected %b", m_last_of_run, e.last));
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_sample(input logic signed [23:0] s);
        req_t r;
        r.command = CMD_SAMPLE;
        r.sample = s;
        r.index = 13'($urandom());
        r.value = 24'($urandom());
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic push_coef(input logic [12:0] idx, input logic signed [23:0] v);
        req_t r;
        r.command = CMD_COEF;
        r.sample = 24'($urandom());
        r.index = idx;
        r.value = v;
        pending_reqs = {pending_reqs, r};
    endtask

    // Small coefficients keep most outputs off the rails, so the rounding is
    // really exercised; a few full-scale words cause saturation.
    function automatic logic signed [23:0] rand_coef();
        if ($urandom_range(9) == 0) return 24'($urandom());
        return 24'($signed($urandom_range(65535)) - 32768);
    endfunction

    // Mostly samples with random content, with rewrites of the row in use
    // mixed in.
    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 85) push_sample(24'($urandom()));
            else push_coef(RowBase + 13'($urandom_range(Taps - 1)), rand_coef());
        end
    endtask

    // Wait until every request is taken and every output has come back, then
    // let the block settle before the step is changed.
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_valid || expected_outs.size() > 0)
            @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_step(input logic [AccW-1:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        step_q16 = v;
    endtask

    initial begin
        for (int i = 0; i < HistDepth; i++) hist_ram[i] = '0;
        for (int i = 0; i < CoefDepth; i++) coef_ram[i] = '0;
        wr_ptr = 0;
        phase_acc = (Ratio - 1) * OneQ16;
        step_q16 = 23'd4194304;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // With a step of 64.0 the accumulator stays on phase Ratio-1 with a
        // zero fraction, so that row is loaded before the first sample.
        for (int t = 0; t < Taps; t++) push_coef(RowBase + 13'(t), rand_coef());

        // Directed part at the reset step, one output per sample: sample
        // extremes, then a full-scale coefficient on the newest tap of the
        // row to drive the output into both rails.
        push_sample(24'sd8388607);
        push_sample(-24'sd8388608);
        push_sample(24'sd0);
        push_sample(-24'sd1);
        push_coef(RowBase, 24'sd8388607);
        push_sample(24'sd8388607);
        push_sample(-24'sd8388608);
        push_coef(RowBase, -24'sd8388608);
        push_sample(24'sd8388607);
        push_coef(RowBase, 24'sd1000);
        push_coef(13'h1FFF, -24'sd20000);
        push_sample(24'sd12345);
        wait_idle();

        // Steps above range are clamped down to 64.0.
        write_step(23'h7FFFFF);
        push_sample(-24'sd5555555);
        push_sample(24'sd2222222);
        wait_idle();
        write_step(23'd4194305);
        push_sample(24'sd6000000);
        wait_idle();

        // Random part, first phase: the receiver stalls far more than the
        // sender.
        write_step(23'($urandom_range(Ratio * OneQ16, 8388607)));
        push_random(9);
        wait_idle();

        // Second phase: the sender idles heavily and the receiver lightly.
        send_idle = 84;
        recv_idle = 30;
        write_step(23'($urandom_range(Ratio * OneQ16, 8388607)));
        push_random(9);
        wait_idle();

        // Last phase: back to back on both sides at the exact step of 64.0.
        send_idle = 0;
        recv_idle = 0;
        write_step(23'd4194304);
        push_random(9);
        wait_idle();

        $display("tb: %0d samples and %0d coefficient writes sent, %0d outputs checked",
                 samples_sent, coefs_sent, outs_checked);
        $display("tb: one table row in use, exact and clamped steps, stalls on both sides");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
